>>> rtl/u8d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg: shared types and codes for the UTF-8 / escape decoder
// Status codes, decode phases, character constants and the decoder state.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int CodeW   = 21;
  localparam int StatusW = 4;
  localparam int PhaseW  = 2;
  localparam int LeftW   = 3;
  localparam int MinW    = 17;

  // decode phases
  localparam logic [PhaseW-1:0] PH_IDLE   = 2'd0;
  localparam logic [PhaseW-1:0] PH_UTF8   = 2'd1;
  localparam logic [PhaseW-1:0] PH_BSLASH = 2'd2;
  localparam logic [PhaseW-1:0] PH_HEX    = 2'd3;

  // result status codes
  localparam logic [StatusW-1:0] ST_OK          = 4'd0;
  localparam logic [StatusW-1:0] ST_END         = 4'd1;
  localparam logic [StatusW-1:0] ST_BAD_START   = 4'd2;
  localparam logic [StatusW-1:0] ST_BAD_CONT    = 4'd3;
  localparam logic [StatusW-1:0] ST_OVERLONG    = 4'd4;
  localparam logic [StatusW-1:0] ST_RANGE       = 4'd5;
  localparam logic [StatusW-1:0] ST_SURROGATE   = 4'd6;
  localparam logic [StatusW-1:0] ST_BS_END      = 4'd7;
  localparam logic [StatusW-1:0] ST_UNKNOWN_ESC = 4'd8;
  localparam logic [StatusW-1:0] ST_SHORT_HEX   = 4'd9;
  localparam logic [StatusW-1:0] ST_TOO_LARGE   = 4'd10;

  localparam logic [CodeW-1:0] UNI_MAX    = 21'h10ffff;
  localparam logic [CodeW-1:0] CODE_CLAMP = 21'h110000;
  localparam logic [CodeW-1:0] SURR_LO    = 21'h00d800;
  localparam logic [CodeW-1:0] SURR_HI    = 21'h00e000;
  localparam logic [CodeW-1:0] SMALL_MAX  = 21'h00007f;

  localparam logic [MinW-1:0] MIN_2BYTE = 17'(1 << 7);
  localparam logic [MinW-1:0] MIN_3BYTE = 17'(1 << 11);
  localparam logic [MinW-1:0] MIN_4BYTE = 17'(1 << 16);

  // bytes with a meaning of their own
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_N       = 8'h6e;
  localparam logic [7:0] CH_R       = 8'h72;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_U_LO    = 8'h75;
  localparam logic [7:0] CH_U_HI    = 8'h55;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] LEAD_MIN   = 8'hc2;
  localparam logic [7:0] LEAD_MAX   = 8'hf4;
  localparam logic [7:0] LEAD_3BYTE = 8'he0;
  localparam logic [7:0] LEAD_4BYTE = 8'hf0;
  localparam logic [7:0] CONT_MIN   = 8'h80;
  localparam logic [7:0] CONT_MAX   = 8'hbf;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [LeftW-1:0]  bytes_left;
    logic [CodeW-1:0]  acc;
    logic [MinW-1:0]   min_code;
    logic              limit_small;
  } dec_state_t;

endpackage

`default_nettype wire

>>> rtl/u8d_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_ifs: valid/ready channels of the decoder
// Byte input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;
  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface u8d_result_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [3:0]  status;
  modport source (output valid, output code_point, output status, input ready);
  modport sink   (input valid, input code_point, input status, output ready);
endinterface

interface u8d_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/utf8_escape_decoder.sv
`default_nettype none
// A byte accepted into the input register passes through the step logic into the result register.
// Throughput: one byte per cycle; the input register advances whenever the
// result register is empty or is being taken.
// Bytes inside a sequence or escape give no result and still move at one per cycle.
// Reset (rst, synchronous): empty registers, idle phase, escape_mode 0.
// ----------------------------------------------------------------------------
// utf8_escape_decoder: byte-serial UTF-8 decoder with backslash escapes
// Input register, single-pass step logic, result register.
// ----------------------------------------------------------------------------
module utf8_escape_decoder (
  input  wire        clk,
  input  wire        rst,
  u8d_byte_if.sink   bytes,
  u8d_result_if.source results,
  u8d_cfg_if.sink    cfg
);
  import u8d_pkg::*;

  logic               escape_mode;
  logic               in_vld;
  logic [7:0]         in_byte;
  logic               in_end;
  dec_state_t         state;
  dec_state_t         state_next;
  logic               emit;
  logic [CodeW-1:0]   step_code;
  logic [StatusW-1:0] step_status;
  logic               out_vld;
  logic [CodeW-1:0]   out_code;
  logic [StatusW-1:0] out_status;
  logic               advance;

  assign advance     = in_vld && (!out_vld || results.ready);
  assign bytes.ready = !in_vld || advance;
  assign cfg.ready   = 1'b1;

  assign results.valid      = out_vld;
  assign results.code_point = out_code;
  assign results.status     = out_status;

  u8d_step u_step (
    .cur         (state),
    .escape_mode (escape_mode),
    .data_byte   (in_byte),
    .end_of_data (in_end),
    .nxt         (state_next),
    .emit        (emit),
    .code_point  (step_code),
    .status      (step_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_mode <= 1'b0;
    end else if (cfg.valid) begin
      escape_mode <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (bytes.ready) begin
      in_vld <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      in_byte <= bytes.data_byte;
      in_end  <= bytes.end_of_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= emit;
    end else if (results.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_code   <= step_code;
      out_status <= step_status;
    end
  end

`ifndef SYNTHESIS
  a_err_zero_code: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.status != ST_OK) |-> results.code_point == '0)
    else $error("nonzero code point with error status");

  a_ok_in_range: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.status == ST_OK) |-> results.code_point <= UNI_MAX)
    else $error("ok result above Unicode range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !bytes.ready |-> (in_vld && out_vld && !results.ready))
    else $error("input stalled without output back-pressure");

  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && emit) |=> (state.phase == PH_IDLE && results.valid))
    else $error("result issued without return to idle");

  a_utf8_count: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_UTF8 |-> (state.bytes_left >= 3'd1 && state.bytes_left <= 3'd3))
    else $error("bad continuation count inside UTF-8 sequence");
`endif

endmodule

`default_nettype wire

>>> rtl/u8d_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_step: next-state and result logic for one byte
// Given the current decode state, mode and byte, gives the next state and an
// optional result (code point and status).
// ----------------------------------------------------------------------------
module u8d_step (
  input  wire u8d_pkg::dec_state_t        cur,
  input  wire                             escape_mode,
  input  wire [7:0]                       data_byte,
  input  wire                             end_of_data,
  output u8d_pkg::dec_state_t             nxt,
  output logic                            emit,
  output logic [u8d_pkg::CodeW-1:0]       code_point,
  output logic [u8d_pkg::StatusW-1:0]     status
);
  import u8d_pkg::*;

  logic [7:0]       b;
  logic [CodeW-1:0] utf_acc;
  logic [3:0]       hex_val;
  logic             hex_ok;
  logic [CodeW+3:0] hex_wide;
  logic [CodeW-1:0] hex_acc;
  logic [CodeW-1:0] hex_limit;

  assign b = end_of_data ? CH_NUL : data_byte;

  // shift in six payload bits, kept to 21 bits
  assign utf_acc = {cur.acc[CodeW-7:0], b[5:0]};

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = b[3:0];
    if (b inside {[8'h30:8'h39]}) begin
      hex_val = b[3:0];
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      hex_val = b[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  // accumulation saturates just above the Unicode range
  assign hex_wide  = {cur.acc, hex_val};
  assign hex_acc   = (hex_wide > {4'd0, UNI_MAX}) ? CODE_CLAMP : hex_wide[CodeW-1:0];
  assign hex_limit = cur.limit_small ? SMALL_MAX : UNI_MAX;

  always_comb begin
    nxt        = cur;
    emit       = 1'b0;
    status     = ST_OK;
    code_point = '0;
    case (cur.phase)
      PH_IDLE: begin
        if (b == CH_NUL) begin
          emit   = 1'b1;
          status = ST_END;
        end else if (b < CONT_MIN) begin
          if (escape_mode && b == CH_BSLASH) begin
            nxt.phase = PH_BSLASH;
          end else begin
            emit       = 1'b1;
            code_point = {13'd0, b};
          end
        end else if (b < LEAD_MIN || b > LEAD_MAX) begin
          emit   = 1'b1;
          status = ST_BAD_START;
        end else begin
          nxt.phase = PH_UTF8;
          if (b < LEAD_3BYTE) begin
            nxt.bytes_left = 3'd1;
            nxt.acc        = {16'd0, b[4:0]};
            nxt.min_code   = MIN_2BYTE;
          end else if (b < LEAD_4BYTE) begin
            nxt.bytes_left = 3'd2;
            nxt.acc        = {17'd0, b[3:0]};
            nxt.min_code   = MIN_3BYTE;
          end else begin
            nxt.bytes_left = 3'd3;
            nxt.acc        = {18'd0, b[2:0]};
            nxt.min_code   = MIN_4BYTE;
          end
        end
      end
      PH_UTF8: begin
        if (b < CONT_MIN || b > CONT_MAX) begin
          emit   = 1'b1;
          status = ST_BAD_CONT;
        end else begin
          nxt.acc = utf_acc;
          if (cur.bytes_left > 3'd1) begin
            nxt.bytes_left = cur.bytes_left - 3'd1;
          end else begin
            emit = 1'b1;
            if (utf_acc < {4'd0, cur.min_code}) begin
              status = ST_OVERLONG;
            end else if (utf_acc > UNI_MAX) begin
              status = ST_RANGE;
            end else if (utf_acc >= SURR_LO && utf_acc < SURR_HI) begin
              status = ST_SURROGATE;
            end else begin
              code_point = utf_acc;
            end
          end
        end
      end
      PH_BSLASH: begin
        case (b)
          CH_NUL: begin
            emit   = 1'b1;
            status = ST_BS_END;
          end
          CH_BSLASH, CH_SQUOTE, CH_DQUOTE: begin
            emit       = 1'b1;
            code_point = {13'd0, b};
          end
          CH_T: begin
            emit       = 1'b1;
            code_point = {13'd0, CH_TAB};
          end
          CH_N: begin
            emit       = 1'b1;
            code_point = {13'd0, CH_LF};
          end
          CH_R: begin
            emit       = 1'b1;
            code_point = {13'd0, CH_CR};
          end
          CH_X: begin
            nxt.phase       = PH_HEX;
            nxt.bytes_left  = 3'd2;
            nxt.limit_small = 1'b1;
            nxt.acc         = '0;
          end
          CH_U_LO: begin
            nxt.phase       = PH_HEX;
            nxt.bytes_left  = 3'd4;
            nxt.limit_small = 1'b0;
            nxt.acc         = '0;
          end
          CH_U_HI: begin
            nxt.phase       = PH_HEX;
            nxt.bytes_left  = 3'd6;
            nxt.limit_small = 1'b0;
            nxt.acc         = '0;
          end
          default: begin
            emit   = 1'b1;
            status = ST_UNKNOWN_ESC;
          end
        endcase
      end
      default: begin
        if (!hex_ok) begin
          emit   = 1'b1;
          status = ST_SHORT_HEX;
        end else begin
          nxt.acc = hex_acc;
          if (cur.bytes_left > 3'd1) begin
            nxt.bytes_left = cur.bytes_left - 3'd1;
          end else begin
            emit = 1'b1;
            if (hex_acc > hex_limit) begin
              status = ST_TOO_LARGE;
            end else begin
              code_point = hex_acc;
            end
          end
        end
      end
    endcase
    if (emit) begin
      nxt.phase      = PH_IDLE;
      nxt.bytes_left = '0;
    end
  end

endmodule

`default_nettype wire
